// ===== src/sbpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Six-button pad port - shared definitions
// Item kinds, per-pad state layout, result beat and the pad word encoder.
// ----------------------------------------------------------------------------
package sbpp_pkg;

  localparam int unsigned NUM_PADS_DEFAULT = 8;
  localparam int unsigned MAX_PADS         = 8;

  localparam int unsigned PAD_W     = 3;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned BTN_W     = 12;
  localparam int unsigned WORD_W    = 7;
  localparam int unsigned TH_BIT    = 6;

  // Result queue depth and its fill count width
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Idle frame count beyond which a tick drops the sequence
  localparam logic [4:0] IDLE_LIMIT = 5'd25;

  // Pad words
  localparam logic [7:0] WORD_IDLE     = 8'h7F;
  localparam logic [7:0] MASK_LOW      = 8'hB3;
  localparam logic [7:0] MASK_LOW_3RD  = 8'hB0;
  localparam logic [7:0] MASK_LOW_4TH  = 8'hBF;

  // Button bit positions in the buttons field
  localparam int unsigned BTN_UP    = 0;
  localparam int unsigned BTN_DOWN  = 1;
  localparam int unsigned BTN_LEFT  = 2;
  localparam int unsigned BTN_RIGHT = 3;
  localparam int unsigned BTN_B     = 4;
  localparam int unsigned BTN_C     = 5;
  localparam int unsigned BTN_A     = 6;
  localparam int unsigned BTN_START = 7;
  localparam int unsigned BTN_Z     = 8;
  localparam int unsigned BTN_Y     = 9;
  localparam int unsigned BTN_X     = 10;
  localparam int unsigned BTN_MODE  = 11;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef struct packed {
    logic       th;
    logic [1:0] edge_cnt;
    logic [4:0] idle;
  } pad_state_t;

  localparam int unsigned STATE_W = $bits(pad_state_t);

  localparam pad_state_t PAD_RESET = '{th: 1'b1, edge_cnt: 2'd0, idle: 5'd0};

  typedef struct packed {
    kind_t              kind;
    logic [PAD_W-1:0]   pad;
    logic [DATA_W-1:0]  write_data;
    logic [BTN_W-1:0]   buttons;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] data;
  } result_t;

  typedef struct packed {
    logic s1_read;
  } upd_status_t;

  // Active-low pad word for the current phase; phase is TH plus twice the
  // edge count on six-button pads.
  function automatic logic [WORD_W-1:0] pad_word(input pad_state_t st, input logic six,
                                                  input logic [BTN_W-1:0] btn);
    logic [2:0]        phase;
    logic [WORD_W-1:0] w;
    logic [BTN_W-1:0]  n;
    n     = ~btn;
    phase = {(six ? st.edge_cnt : 2'd0), st.th};
    unique case (phase) inside
      3'd1, 3'd3, 3'd5: begin
        w = {1'b1, n[BTN_C], n[BTN_B], n[BTN_RIGHT], n[BTN_LEFT], n[BTN_DOWN], n[BTN_UP]};
      end
      3'd0, 3'd2: begin
        w = {1'b1, n[BTN_START], n[BTN_A], 2'b11, n[BTN_DOWN], n[BTN_UP]}
            & MASK_LOW[WORD_W-1:0];
      end
      3'd4: begin
        w = {1'b1, n[BTN_START], n[BTN_A], 4'b1111} & MASK_LOW_3RD[WORD_W-1:0];
      end
      3'd6: begin
        w = {1'b1, n[BTN_START], n[BTN_A], 4'b1111} & MASK_LOW_4TH[WORD_W-1:0];
      end
      default: begin
        w = {1'b1, n[BTN_C], n[BTN_B], n[BTN_MODE], n[BTN_X], n[BTN_Y], n[BTN_Z]};
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== src/sbpp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sbpp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/sbpp_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Six-button pad port - pad state update
// Read the pad state RAM on accept, modify in the next cycle, write back.
// ----------------------------------------------------------------------------
module sbpp_update import sbpp_pkg::*; #(
  parameter int unsigned NUM_PADS = NUM_PADS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire item_t                item,
  input  wire logic [MAX_PADS-1:0]  mask,
  output result_t                   result,
  output upd_status_t               status
);

  localparam int unsigned PAD_AW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
  localparam logic [PAD_W:0] PAD_LIMIT = (PAD_W + 1)'(NUM_PADS);

  logic                  s1_valid;
  item_t                 s1_item;
  logic [NUM_PADS-1:0]   entry_valid;
  logic                  lw_valid;
  logic [PAD_AW-1:0]     lw_addr;
  pad_state_t            lw_data;

  logic [STATE_W-1:0]    ram_rdata;
  logic [PAD_AW-1:0]     s1_addr;
  logic                  s1_in_range;
  logic                  six;
  pad_state_t            cur;
  pad_state_t            nxt;
  logic                  wr_en;

  assign s1_addr     = s1_item.pad[PAD_AW-1:0];
  assign s1_in_range = {1'b0, s1_item.pad} < PAD_LIMIT;
  assign six         = mask[s1_item.pad];

  // Advance the stage; payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_item <= item;
    end
  end

  sbpp_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUM_PADS),
    .AW    (PAD_AW)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (nxt),
    .raddr (item.pad[PAD_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Forward the write that landed on the read edge; unwritten entries read as reset
  always_comb begin
    if (lw_valid && (lw_addr == s1_addr)) begin
      cur = lw_data;
    end else if (s1_in_range && entry_valid[s1_addr]) begin
      cur = pad_state_t'(ram_rdata);
    end else begin
      cur = PAD_RESET;
    end
  end

  always_comb begin
    nxt           = cur;
    wr_en         = 1'b0;
    result.valid  = 1'b0;
    result.data   = WORD_IDLE[WORD_W-1:0];
    case (s1_item.kind)
      KIND_READ: begin
        result.valid = s1_valid;
        if (s1_in_range) begin
          result.data = pad_word(cur, six, s1_item.buttons);
        end
      end
      KIND_WRITE: begin
        wr_en  = s1_valid && s1_in_range;
        nxt.th = s1_item.write_data[TH_BIT];
        if (six && !cur.th && s1_item.write_data[TH_BIT]) begin
          nxt.edge_cnt = cur.edge_cnt + 2'd1;
          nxt.idle     = 5'd0;
        end
      end
      KIND_TICK: begin
        wr_en = s1_valid && s1_in_range && six;
        if (cur.idle > IDLE_LIMIT) begin
          nxt.edge_cnt = 2'd0;
          nxt.idle     = 5'd0;
        end else begin
          nxt.idle = cur.idle + 5'd1;
        end
      end
      KIND_CLEAR: begin
        wr_en        = s1_valid && s1_in_range && six;
        nxt.edge_cnt = 2'd0;
        nxt.idle     = 5'd0;
      end
    endcase
  end

  assign status.s1_read = s1_valid && (s1_item.kind == KIND_READ);

  // Hold the last write for forwarding and mark the entry as written
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid    <= 1'b0;
      entry_valid <= '0;
    end else begin
      lw_valid <= wr_en;
      if (wr_en) begin
        entry_valid[s1_addr] <= 1'b1;
      end
    end
    if (wr_en) begin
      lw_addr <= s1_addr;
      lw_data <= nxt;
    end
  end

  a_idle_bounded: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> nxt.idle <= (IDLE_LIMIT + 5'd1))
    else $error("stored idle count beyond limit");

  a_out_of_range_idle: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !s1_in_range) |-> result.data == WORD_IDLE[WORD_W-1:0])
    else $error("read of absent pad not idle word");

  a_write_needs_item: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (s1_valid && s1_in_range && (s1_item.kind != KIND_READ)))
    else $error("state write without a pad update");

endmodule
`default_nettype wire

// ===== src/sbpp_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Six-button pad port - result queue
// Small queue of read results between the update stage and the output.
// ----------------------------------------------------------------------------
module sbpp_out_fifo import sbpp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire result_t               push,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic [WORD_W-1:0]          out_data,
  output logic [FIFO_CNT_W-1:0]      count
);

  logic [WORD_W-1:0]     mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    head;
  logic [FIFO_AW-1:0]    tail;
  logic [FIFO_CNT_W-1:0] count_next;
  logic                  pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[head];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    count_next = count;
    if (push.valid && !pop) begin
      count_next = count + FIFO_CNT_W'(1);
    end else if (!push.valid && pop) begin
      count_next = count - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push.valid) begin
        tail <= tail + FIFO_AW'(1);
      end
      if (pop) begin
        head <= head + FIFO_AW'(1);
      end
    end
    if (push.valid) begin
      mem[tail] <= push.data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> count != FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result pushed into full queue");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== src/six_button_pad_port_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Six-button pad port core
// Up to NUM_PADS game-pad ports with TH select lines and six-button
// sequencing; reads return the active-low pad word.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_stall is low. Each item reads
// its pad's state from a small synchronous RAM on the accept edge, is updated
// in the following cycle and written back at the end of it; a write that lands
// on the edge at which the next item reads the same pad is forwarded, so items
// to one pad may follow back to back. A read passes the update stage register
// and the result queue before its beat is presented on the output; writes,
// ticks and clears produce none. Read results wait in a four-deep queue, and
// in_stall rises only when the queue plus the read in the update stage would
// fill it, so with out_stall low the input never stalls. After reset every pad
// reads as TH high with no sequence in progress; no clearing pass is needed,
// the block is ready on the cycle after reset. The user must write the
// six-button mask through cfg_we / cfg_wdata only while idle; not enforced.
// ----------------------------------------------------------------------------
module six_button_pad_port_core import sbpp_pkg::*; #(
  parameter int unsigned NUM_PADS = NUM_PADS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic [MAX_PADS-1:0] cfg_wdata,
  // input beat
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          kind,
  input  wire logic [PAD_W-1:0]    pad,
  input  wire logic [DATA_W-1:0]   write_data,
  input  wire logic [BTN_W-1:0]    buttons,
  // output beat
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [WORD_W-1:0]        read_data
);

  logic [MAX_PADS-1:0]     six_button_mask;
  logic                    accept;
  item_t                   item;
  result_t                 result;
  upd_status_t             status;
  logic [FIFO_CNT_W-1:0]   fifo_count;
  logic [FIFO_CNT_W:0]     pending;

  // Mask register: 1 marks a six-button pad
  always_ff @(posedge clk) begin
    if (rst) begin
      six_button_mask <= '0;
    end else if (cfg_we) begin
      six_button_mask <= cfg_wdata;
    end
  end

  // Stall once queued results plus the read in flight would fill the queue
  assign pending  = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(status.s1_read);
  assign in_stall = pending >= (FIFO_CNT_W + 1)'(FIFO_DEPTH);
  assign accept   = in_valid && !in_stall;

  assign item.kind       = kind_t'(kind);
  assign item.pad        = pad;
  assign item.write_data = write_data;
  assign item.buttons    = buttons;

  sbpp_update #(
    .NUM_PADS (NUM_PADS)
  ) u_update (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .mask   (six_button_mask),
    .result (result),
    .status (status)
  );

  sbpp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (read_data),
    .count     (fifo_count)
  );

  a_read_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind_t'(kind) == KIND_READ)) |=> status.s1_read)
    else $error("accepted read lost before update stage");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (fifo_count == FIFO_CNT_W'(FIFO_DEPTH)) |-> !accept)
    else $error("item accepted with result queue full");

endmodule
`default_nettype wire
